@@ rtl/ecpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ecpa_pkg: shared types and constants of the EC point adder
// Sequencer states, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_GO,
    S_RED_W,
    S_SPLIT,
    S_SQ_GO,
    S_SQ_W,
    S_NUM3,
    S_NUMA,
    S_SRCH,
    S_KK_GO,
    S_KK_W,
    S_X3A,
    S_X3B,
    S_DIFF,
    S_KD_GO,
    S_KD_W,
    S_Y3,
    S_OUT
  } ecpa_state_e;

  typedef enum logic [2:0] {
    R_X1,
    R_Y1,
    R_X2,
    R_Y2,
    R_A
  } ecpa_red_e;

  localparam logic [0:0] CfgFieldPrime = 1'b0;
  localparam logic [0:0] CfgCurveCoefA = 1'b1;

  localparam int unsigned FieldPrimeRst = 11;
  localparam int unsigned CurveCoefARst = 1;
  localparam int unsigned MinPrime      = 3;

endpackage

@@ rtl/ecpa_in_if.sv @@
// ----------------------------------------------------------------------------
// ecpa_in_if: input channel of the EC point adder
// One word carries two affine points with infinity flags.
// ----------------------------------------------------------------------------
interface ecpa_in_if #(
  parameter int unsigned FIELD_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] first_x;
  logic [FIELD_BITS-1:0] first_y;
  logic                  first_inf;
  logic [FIELD_BITS-1:0] second_x;
  logic [FIELD_BITS-1:0] second_y;
  logic                  second_inf;

  modport source (
    output valid, first_x, first_y, first_inf, second_x, second_y, second_inf,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_inf, second_x, second_y, second_inf,
    output ready
  );
endinterface

@@ rtl/ecpa_out_if.sv @@
// ----------------------------------------------------------------------------
// ecpa_out_if: output channel of the EC point adder
// One word carries the sum point and its infinity flag.
// ----------------------------------------------------------------------------
interface ecpa_out_if #(
  parameter int unsigned FIELD_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] sum_x;
  logic [FIELD_BITS-1:0] sum_y;
  logic                  sum_inf;

  modport source (
    output valid, sum_x, sum_y, sum_inf,
    input  ready
  );
  modport sink (
    input  valid, sum_x, sum_y, sum_inf,
    output ready
  );
endinterface

@@ rtl/ec_point_add_prime_field.sv @@
// ----------------------------------------------------------------------------
// ec_point_add_prime_field: elliptic curve point adder over GF(p)
// Adds two affine points on y^2 = x^3 + ax + b with a small sequencer around
// one bit-serial modular multiplier and a slope search by repeated addition.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        first_x/y/inf, second_x/y/inf
//   out_o    out  valid/ready        sum_x, sum_y, sum_inf
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// One word takes 5 reductions and up to 3 modular products around the slope
// search, which gives infinity when no slope exists; a modulus below 3 gives
// infinity without any reduction.
// in_i is ready only in idle; a finished word waits in the output register
// while the next word is taken. rst_ni restores p = 11, a = 1.
// ----------------------------------------------------------------------------
module ec_point_add_prime_field import ecpa_pkg::*; #(
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i,
  ecpa_in_if.sink               in_i,
  ecpa_out_if.source            out_o
);

  localparam int unsigned W = FIELD_BITS;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_sub(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mod_3(input logic [W-1:0] t, input logic [W-1:0] p);
    logic [W+1:0] s;
    s = {2'b00, t} + {1'b0, t, 1'b0};
    if (s >= {1'b0, p, 1'b0}) begin
      s = s - {1'b0, p, 1'b0};
    end else if (s >= {2'b00, p}) begin
      s = s - {2'b00, p};
    end
    return s[W-1:0];
  endfunction

  ecpa_state_e state_q, state_d;
  ecpa_red_e   r_q, r_d;

  logic [W-1:0] p_q, a_q;
  logic [W-1:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d, ar_q, ar_d;
  logic         inf1_q, inf1_d, inf2_q, inf2_d;
  logic [W-1:0] num_q, num_d, den_q, den_d, acc_q, acc_d, k_q, k_d;
  logic [W-1:0] t_q, t_d, x3_q, x3_d;
  logic [W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic         rinf_q, rinf_d;
  logic         ov_q, ov_d;
  logic [W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic         sinf_q, sinf_d;

  logic         mm_start;
  logic [W-1:0] mm_m, mm_y, mm_res;
  logic         mm_done;

  ecpa_mulmod #(.FB(W)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .m_i     (mm_m),
    .y_i     (mm_y),
    .p_i     (p_q),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= W'(FieldPrimeRst);
      a_q <= W'(CurveCoefARst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFieldPrime: p_q <= cfg_data_i;
        CfgCurveCoefA: a_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    x2_d     = x2_q;
    y2_d     = y2_q;
    ar_d     = ar_q;
    inf1_d   = inf1_q;
    inf2_d   = inf2_q;
    num_d    = num_q;
    den_d    = den_q;
    acc_d    = acc_q;
    k_d      = k_q;
    t_d      = t_q;
    x3_d     = x3_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rinf_d   = rinf_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    sinf_d   = sinf_q;
    ov_d     = ov_q && !out_o.ready;
    mm_start = 1'b0;
    mm_m     = k_q;
    mm_y     = k_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x1_d   = in_i.first_x;
          y1_d   = in_i.first_y;
          inf1_d = in_i.first_inf;
          x2_d   = in_i.second_x;
          y2_d   = in_i.second_y;
          inf2_d = in_i.second_inf;
          if (p_q < W'(MinPrime)) begin
            rx_d    = '0;
            ry_d    = '0;
            rinf_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            r_d     = R_X1;
            state_d = S_RED_GO;
          end
        end
      end
      S_RED_GO: begin
        mm_start = 1'b1;
        mm_y     = W'(1);
        case (r_q)
          R_X1:    mm_m = x1_q;
          R_Y1:    mm_m = y1_q;
          R_X2:    mm_m = x2_q;
          R_Y2:    mm_m = y2_q;
          default: mm_m = a_q;
        endcase
        state_d = S_RED_W;
      end
      S_RED_W: begin
        if (mm_done) begin
          state_d = S_RED_GO;
          case (r_q)
            R_X1: begin
              x1_d = mm_res;
              r_d  = R_Y1;
            end
            R_Y1: begin
              y1_d = mm_res;
              r_d  = R_X2;
            end
            R_X2: begin
              x2_d = mm_res;
              r_d  = R_Y2;
            end
            R_Y2: begin
              y2_d = mm_res;
              r_d  = R_A;
            end
            default: begin
              ar_d    = mm_res;
              state_d = S_SPLIT;
            end
          endcase
        end
      end
      S_SPLIT: begin
        acc_d = '0;
        k_d   = '0;
        if (inf1_q) begin
          rx_d    = inf2_q ? '0 : x2_q;
          ry_d    = inf2_q ? '0 : y2_q;
          rinf_d  = inf2_q;
          state_d = S_OUT;
        end else if (inf2_q) begin
          rx_d    = x1_q;
          ry_d    = y1_q;
          rinf_d  = 1'b0;
          state_d = S_OUT;
        end else if (x1_q == x2_q) begin
          if (y1_q != y2_q || y1_q == '0) begin
            rx_d    = '0;
            ry_d    = '0;
            rinf_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            den_d   = mod_add(y1_q, y1_q, p_q);
            state_d = S_SQ_GO;
          end
        end else begin
          num_d   = mod_sub(y2_q, y1_q, p_q);
          den_d   = mod_sub(x2_q, x1_q, p_q);
          state_d = S_SRCH;
        end
      end
      S_SQ_GO: begin
        mm_start = 1'b1;
        mm_m     = x1_q;
        mm_y     = x1_q;
        state_d  = S_SQ_W;
      end
      S_SQ_W: begin
        if (mm_done) begin
          t_d     = mm_res;
          state_d = S_NUM3;
        end
      end
      S_NUM3: begin
        num_d   = mod_3(t_q, p_q);
        state_d = S_NUMA;
      end
      S_NUMA: begin
        num_d   = mod_add(num_q, ar_q, p_q);
        state_d = S_SRCH;
      end
      S_SRCH: begin
        if (acc_q == num_q) begin
          state_d = S_KK_GO;
        end else if (k_q == p_q - 1'b1) begin
          rx_d    = '0;
          ry_d    = '0;
          rinf_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          acc_d = mod_add(acc_q, den_q, p_q);
          k_d   = k_q + 1'b1;
        end
      end
      S_KK_GO: begin
        mm_start = 1'b1;
        state_d  = S_KK_W;
      end
      S_KK_W: begin
        if (mm_done) begin
          t_d     = mm_res;
          state_d = S_X3A;
        end
      end
      S_X3A: begin
        t_d     = mod_sub(t_q, x1_q, p_q);
        state_d = S_X3B;
      end
      S_X3B: begin
        x3_d    = mod_sub(t_q, x2_q, p_q);
        state_d = S_DIFF;
      end
      S_DIFF: begin
        t_d     = mod_sub(x1_q, x3_q, p_q);
        state_d = S_KD_GO;
      end
      S_KD_GO: begin
        mm_start = 1'b1;
        mm_y     = t_q;
        state_d  = S_KD_W;
      end
      S_KD_W: begin
        if (mm_done) begin
          t_d     = mm_res;
          state_d = S_Y3;
        end
      end
      S_Y3: begin
        rx_d    = x3_q;
        ry_d    = mod_sub(t_q, y1_q, p_q);
        rinf_d  = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          sx_d    = rx_q;
          sy_d    = ry_q;
          sinf_d  = rinf_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q     <= R_X1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    x2_q   <= x2_d;
    y2_q   <= y2_d;
    ar_q   <= ar_d;
    inf1_q <= inf1_d;
    inf2_q <= inf2_d;
    num_q  <= num_d;
    den_q  <= den_d;
    acc_q  <= acc_d;
    k_q    <= k_d;
    t_q    <= t_d;
    x3_q   <= x3_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    rinf_q <= rinf_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    sinf_q <= sinf_d;
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = ov_q;
  assign out_o.sum_x   = sx_q;
  assign out_o.sum_y   = sy_q;
  assign out_o.sum_inf = sinf_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q != S_IDLE)
    else $error("accepted word did not start the sequencer");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.sum_inf |-> out_o.sum_x == '0 && out_o.sum_y == '0)
    else $error("infinity result with nonzero coordinates");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_OUT))
    else $error("output word raised outside the output state");

  a_mm_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> state_q == S_RED_W || state_q == S_SQ_W || state_q == S_KK_W ||
                state_q == S_KD_W)
    else $error("multiplier finished while sequencer was not waiting");

endmodule

@@ rtl/ecpa_mulmod.sv @@
// ----------------------------------------------------------------------------
// ecpa_mulmod: bit-serial modular multiplier
// Horner double-and-add, one multiplier bit per cycle: res = m * y mod p.
// y must be below p; m may be any value, so y = 1 reduces m modulo p.
// ----------------------------------------------------------------------------
module ecpa_mulmod #(
  parameter int unsigned FB = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [FB-1:0] m_i,
  input  logic [FB-1:0] y_i,
  input  logic [FB-1:0] p_i,
  output logic          done_o,
  output logic [FB-1:0] res_o
);

  localparam int unsigned CW = $clog2(FB + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [FB-1:0] acc_q, acc_d;
  logic [FB-1:0] m_q, m_d;
  logic [FB-1:0] y_q, y_d;
  logic [FB+1:0] sum;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    m_d    = m_q;
    y_d    = y_q;
    sum    = {1'b0, acc_q, 1'b0} + (m_q[FB-1] ? {2'b00, y_q} : '0);
    if (sum >= {1'b0, p_i, 1'b0}) begin
      sum = sum - {1'b0, p_i, 1'b0};
    end else if (sum >= {2'b00, p_i}) begin
      sum = sum - {2'b00, p_i};
    end
    if (start_i) begin
      cnt_d = CW'(FB);
      acc_d = '0;
      m_d   = m_i;
      y_d   = y_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
      acc_d  = sum[FB-1:0];
      m_d    = {m_q[FB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    m_q   <= m_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ test/ecpa_sum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpa_sum_checker: scoreboard for the EC point adder
// Watches the config port and both channels. Each accepted input word is
// turned into its expected sum point by a local model of the curve arithmetic
// under the current p and a; each accepted output word is compared field by
// field with the oldest expected sum.
// ----------------------------------------------------------------------------
module ecpa_sum_checker import ecpa_pkg::*; #(
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i,
  ecpa_in_if                    in_w,
  ecpa_out_if                   out_w,
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);

  typedef struct packed {
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic                  inf;
  } point_t;

  localparam int unsigned MaxPrints = 100;

  point_t                sums_due [$];
  logic [FIELD_BITS-1:0] prime_q;
  logic [FIELD_BITS-1:0] coef_q;
  int unsigned           fails;
  int unsigned           checked;

  assign fail_cnt_o = fails;
  assign checked_o  = checked;

  initial begin
    fails   = 0;
    checked = 0;
  end

  function automatic point_t point_sum(input logic [FIELD_BITS-1:0] ax, ay,
                                       input logic ainf,
                                       input logic [FIELD_BITS-1:0] bx, by,
                                       input logic binf);
    longint unsigned p, x1, y1, x2, y2, ca, num, den, k, acc, x3, y3;
    point_t          r;
    r     = '0;
    r.inf = 1'b1;
    p     = prime_q;
    if (p < MinPrime) return r;
    x1 = ax % p;
    y1 = ay % p;
    x2 = bx % p;
    y2 = by % p;
    ca = coef_q % p;
    if (ainf) begin
      if (binf) return r;
      r.x   = x2[FIELD_BITS-1:0];
      r.y   = y2[FIELD_BITS-1:0];
      r.inf = 1'b0;
      return r;
    end
    if (binf) begin
      r.x   = x1[FIELD_BITS-1:0];
      r.y   = y1[FIELD_BITS-1:0];
      r.inf = 1'b0;
      return r;
    end
    if (x1 == x2) begin
      if (y1 != y2 || y1 == 0) return r;
      num = (3 * ((x1 * x1) % p) + ca) % p;
      den = (2 * y1) % p;
    end else begin
      num = (y2 + p - y1) % p;
      den = (x2 + p - x1) % p;
    end
    // smallest slope k with den*k == num
    k   = 0;
    acc = 0;
    while (k < p && acc != num) begin
      acc = (acc + den) % p;
      k++;
    end
    if (k == p) return r;
    x3    = ((k * k) % p + 2 * p - x1 - x2) % p;
    y3    = ((k * ((x1 + p - x3) % p)) % p + p - y1) % p;
    r.x   = x3[FIELD_BITS-1:0];
    r.y   = y3[FIELD_BITS-1:0];
    r.inf = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fails++;
    if (fails <= MaxPrints)
      $display("MISMATCH word %0d %s: got %0h, expected %0h", checked, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      prime_q = FIELD_BITS'(FieldPrimeRst);
      coef_q  = FIELD_BITS'(CurveCoefARst);
      sums_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgFieldPrime) prime_q = cfg_data_i;
        else if (cfg_idx_i == CfgCurveCoefA) coef_q = cfg_data_i;
      end
      if (out_w.valid && out_w.ready) begin
        if (sums_due.size() == 0) begin
          report_mismatch("unexpected word, sum_x", out_w.sum_x, 0);
        end else begin
          want = sums_due.pop_front();
          if (out_w.sum_x !== want.x) report_mismatch("sum_x", out_w.sum_x, want.x);
          if (out_w.sum_y !== want.y) report_mismatch("sum_y", out_w.sum_y, want.y);
          if (out_w.sum_inf !== want.inf) report_mismatch("sum_inf", out_w.sum_inf, want.inf);
          checked++;
        end
      end
      if (in_w.valid && in_w.ready)
        sums_due.push_back(point_sum(in_w.first_x, in_w.first_y, in_w.first_inf,
                                     in_w.second_x, in_w.second_y, in_w.second_inf));
      pending_o = sums_due.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the EC point adder
// Drives directed point pairs (infinity operands, doubling, inverse points,
// unreduced coordinates, extreme and composite moduli) and then random phases
// under many curve settings, with random idling on both channels and one long
// output stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import ecpa_pkg::*;

  localparam int unsigned FB         = 16;
  localparam int unsigned MaxWord    = (1 << FB) - 1;
  localparam int unsigned MaxCoef    = MaxWord - 1;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned LongHold   = 600;
  localparam int unsigned NumPhases  = 14;
  localparam int unsigned PhaseWords = 58;
  localparam int unsigned SmallPrimes [20] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31,
                                               37, 41, 43, 47, 53, 61, 97, 101, 251, 257};
  localparam int unsigned Composites [6] = '{9, 15, 21, 25, 91, 255};

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [0:0]    cfg_idx_i;
  logic [FB-1:0] cfg_data_i;
  int unsigned   fail_cnt;
  int unsigned   pending;
  int unsigned   checked;
  int unsigned   cycles;
  int unsigned   settings;
  int unsigned   cur_p;
  bit            gaps_on;
  bit            long_hold;

  ecpa_in_if  #(.FIELD_BITS(FB)) in_w  ();
  ecpa_out_if #(.FIELD_BITS(FB)) out_w ();

  ec_point_add_prime_field #(.FIELD_BITS(FB)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_w.sink),
    .out_o      (out_w.source)
  );

  ecpa_sum_checker #(.FIELD_BITS(FB)) u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_w       (in_w),
    .out_w      (out_w),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // output side: random back-pressure bursts plus one long hold on request
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        out_w.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_w.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  function automatic logic [FB-1:0] rand_word();
    return FB'($urandom_range(0, MaxWord));
  endfunction

  // residue v written as a random raw coordinate congruent to it
  function automatic logic [FB-1:0] lift(input int unsigned v, input int unsigned p);
    return FB'(v + p * $urandom_range(0, (MaxWord - v) / p));
  endfunction

  task automatic set_curve(input int unsigned p, input int unsigned a);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFieldPrime;
    cfg_data_i <= FB'(p);
    @(negedge clk_i);
    cfg_idx_i  <= CfgCurveCoefA;
    cfg_data_i <= FB'(a);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_p = p;
    settings++;
  endtask

  task automatic drive_pair(input logic [FB-1:0] x1, y1, input logic i1,
                            input logic [FB-1:0] x2, y2, input logic i2);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_w.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.first_x    <= x1;
    in_w.first_y    <= y1;
    in_w.first_inf  <= i1;
    in_w.second_x   <= x2;
    in_w.second_y   <= y2;
    in_w.second_inf <= i2;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [FB-1:0] x1, y1, x2, y2;
    logic          i1, i2;
    int unsigned   kind;
    x1   = rand_word();
    y1   = rand_word();
    x2   = rand_word();
    y2   = rand_word();
    i1   = 1'b0;
    i2   = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      x2 = lift(x1 % cur_p, cur_p);
      y2 = lift(y1 % cur_p, cur_p);
    end else if (kind < 35) begin
      x2 = lift(x1 % cur_p, cur_p);
      y2 = lift((cur_p - y1 % cur_p) % cur_p, cur_p);
    end else if (kind < 42) begin
      y1 = lift(0, cur_p);
      x2 = lift(x1 % cur_p, cur_p);
      y2 = lift(0, cur_p);
    end else if (kind < 50) begin
      x2 = lift(x1 % cur_p, cur_p);
    end else if (kind < 58) begin
      i1 = 1'b1;
    end else if (kind < 66) begin
      i2 = 1'b1;
    end else if (kind < 69) begin
      i1 = 1'b1;
      i2 = 1'b1;
    end
    drive_pair(x1, y1, i1, x2, y2, i2);
  endtask

  task automatic pick_curve();
    int unsigned p, a;
    if ($urandom_range(0, 4) == 0) p = Composites[$urandom_range(0, 5)];
    else p = SmallPrimes[$urandom_range(0, 19)];
    case ($urandom_range(0, 3))
      0:       a = 0;
      1:       a = MaxCoef;
      default: a = $urandom_range(0, MaxCoef);
    endcase
    set_curve(p, a);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgFieldPrime;
    cfg_data_i      = '0;
    in_w.valid      = 1'b0;
    in_w.first_x    = '0;
    in_w.first_y    = '0;
    in_w.first_inf  = 1'b0;
    in_w.second_x   = '0;
    in_w.second_y   = '0;
    in_w.second_inf = 1'b0;
    gaps_on         = 1'b1;
    long_hold       = 1'b0;
    settings        = 1;
    cur_p           = FieldPrimeRst;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset curve p = 11, a = 1
    drive_pair(16'hFFFF, 16'hFFFF, 1'b1, 16'd3, 16'd6, 1'b0);
    drive_pair(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
    drive_pair(16'd1, 16'd2, 1'b1, 16'd3, 16'd4, 1'b1);
    drive_pair(16'd0, 16'd0, 1'b1, 16'h00FF, 16'hFFFF, 1'b0);
    drive_pair(16'd3, 16'd6, 1'b0, 16'd3, 16'd6, 1'b0);
    drive_pair(16'd5, 16'd0, 1'b0, 16'd5, 16'd0, 1'b0);
    drive_pair(16'd5, 16'd11, 1'b0, 16'd16, 16'd0, 1'b0);
    drive_pair(16'd3, 16'd6, 1'b0, 16'd3, 16'd5, 1'b0);
    drive_pair(16'd3, 16'd6, 1'b0, 16'd14, 16'd16, 1'b0);
    drive_pair(16'd0, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_pair(16'd1, 16'd2, 1'b0, 16'd7, 16'd9, 1'b0);
    drive_pair(16'd4, 16'd1, 1'b0, 16'd4, 16'd3, 1'b0);
    drive_pair(16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0);
    drive_pair(16'd10, 16'd10, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    drain();

    // smallest field, a = 0
    set_curve(MinPrime, 0);
    drive_pair(16'd1, 16'd1, 1'b0, 16'd1, 16'd1, 1'b0);
    drive_pair(16'd0, 16'd1, 1'b0, 16'd2, 16'd2, 1'b0);
    drive_pair(16'd2, 16'd0, 1'b0, 16'd1, 16'd1, 1'b0);
    drain();

    // composite modulus: one slope without solution, one with
    set_curve(15, 7);
    drive_pair(16'd0, 16'd1, 1'b0, 16'd3, 16'd2, 1'b0);
    drive_pair(16'd0, 16'd0, 1'b0, 16'd5, 16'd5, 1'b0);
    drain();

    // modulus below the minimum
    set_curve(2, 0);
    drive_pair(16'd1, 16'd1, 1'b0, 16'd0, 16'd1, 1'b0);
    drive_pair(16'd1, 16'd1, 1'b1, 16'd0, 16'd1, 1'b0);
    drain();

    // largest prime field, a = 65534
    set_curve(65521, MaxCoef);
    drive_pair(16'hFFFF, 16'd7, 1'b0, 16'd14, 16'd7, 1'b0);
    drive_pair(16'd0, 16'd0, 1'b0, 16'hFFF0, 16'h1234, 1'b0);
    drive_pair(16'd100, 16'd5, 1'b0, 16'd100, 16'd65516, 1'b0);
    drain();

    // largest modulus, no slope exists: full search
    set_curve(MaxWord, MaxCoef);
    drive_pair(16'd0, 16'd0, 1'b0, 16'd3, 16'd1, 1'b0);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      pick_curve();
      for (int n = 0; n < PhaseWords; n++) begin
        if (ph == 1 && n == 10) long_hold = 1'b1;
        send_random();
      end
      drain();
    end

    set_curve(4093, $urandom_range(0, MaxCoef));
    repeat (15) send_random();
    drain();

    gaps_on = 1'b0;
    set_curve(SmallPrimes[$urandom_range(0, 19)], $urandom_range(0, MaxCoef));
    repeat (100) send_random();
    drain();
    repeat (20) @(negedge clk_i);

    $display("Covered %0d words over %0d curve settings: infinity operands, doubling,",
             checked, settings);
    $display("inverse points, unreduced coordinates, composite and extreme moduli, stalls.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ecpa_pkg.sv
rtl/ecpa_in_if.sv
rtl/ecpa_out_if.sv
rtl/ecpa_mulmod.sv
rtl/ec_point_add_prime_field.sv
test/ecpa_sum_checker.sv
test/tb.sv
